// File: design/spe_pkg.sv
package spe_pkg;

  // defaults for the top-level parameters
  localparam int MODEL_WIDTH_DEF  = 512;
  localparam int MAX_POSITION_DEF = 2048;
  localparam int CORDIC_STEPS_DEF = 16;

  // field widths
  localparam int POS_W  = 11;
  localparam int COL_W  = 12;
  localparam int VAL_W  = 16;
  localparam int CODE_W = 14;   // rounded code lies in [-4096, 4096]

  // inverse frequency, unsigned q32, reaches exactly 1.0 for the first pair
  localparam int INV_W = 33;
  // position times inverse frequency
  localparam int PROD_W = POS_W + INV_W;
  // angle after reduction by two pi (q32)
  localparam int ANG_W = 35;
  // quotient bits of the reduction: 2047 * 2^32 / (2 pi in q32) < 2^9
  localparam int ANG_QBITS = 9;
  // cordic datapath width (q30 signed)
  localparam int CD_W = 32;
  // folded angle before the [-pi, pi) wrap (q30, signed, with headroom)
  localparam int TH_W = 34;

  localparam logic [63:0] LN2_Q32     = 64'd2977044472;
  localparam logic [63:0] LN10000_Q32 = 64'd39558110683;
  localparam logic [63:0] TWO_PI_Q32  = 64'd26986075409;
  localparam logic [63:0] ONE_Q32     = 64'h0000_0001_0000_0000;

  localparam logic signed [TH_W-1:0] PI_Q30      = 34'sd3373259426;
  localparam logic signed [TH_W-1:0] TWO_PI_Q30  = 34'sd6746518852;
  localparam logic signed [TH_W-1:0] HALF_PI_Q30 = 34'sd1686629713;
  localparam logic signed [CD_W-1:0] GAIN_Q30    = 32'sd652032874;

  localparam logic signed [CD_W-1:0] ATAN_Q30 [24] = '{
    32'sd843314856, 32'sd497837829, 32'sd263043836, 32'sd133525158,
    32'sd67021686,  32'sd33543515,  32'sd16775850,  32'sd8388437,
    32'sd4194282,   32'sd2097149,   32'sd1048575,   32'sd524287,
    32'sd262143,    32'sd131071,    32'sd65535,     32'sd32767,
    32'sd16384,     32'sd8192,      32'sd4096,      32'sd2048,
    32'sd1024,      32'sd512,       32'sd256,       32'sd128
  };

  // side information that rides along with each item through the pipeline
  typedef struct packed {
    logic                    odd;    // cosine column
    logic                    pass;   // column outside the coded range
    logic                    neg;    // angle was folded by pi
    logic signed [VAL_W-1:0] elem;
  } tag_t;

  // exp(-x) in q32 via ln2 range split and a truncated taylor series,
  // only evaluated at elaboration to fill the frequency rom
  function automatic logic [INV_W-1:0] inv_freq(input logic [63:0] xq);
    logic [63:0] n;
    logic [63:0] r;
    logic [63:0] term;
    longint      sm;
    n    = xq / LN2_Q32;
    r    = xq - n * LN2_Q32;
    sm   = longint'(ONE_Q32);
    term = ONE_Q32;
    for (int K = 1; K <= 20; K++) begin
      term = ((term * r) >> 32) / 64'(K);
      if ((K & 1) != 0) sm = sm - longint'(term);
      else              sm = sm + longint'(term);
    end
    if (sm < 0) sm = 0;
    if (n >= 63) return '0;
    return INV_W'(64'(sm) >> n);
  endfunction

endpackage

// File: design/spe_angle_mod.sv
module spe_angle_mod (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           en,
  input  logic                           in_valid,
  input  logic [spe_pkg::PROD_W-1:0]     in_prod,
  input  spe_pkg::tag_t                  in_tag,
  output logic                           out_valid,
  output logic [spe_pkg::ANG_W-1:0]      out_ang,
  output spe_pkg::tag_t                  out_tag
);

  localparam int NS = spe_pkg::ANG_QBITS;

  logic                          v_r   [NS];
  logic [spe_pkg::PROD_W-1:0]    rem_r [NS];
  spe_pkg::tag_t                 tag_r [NS];

  // restoring reduction, one quotient bit per stage, msb first
  for (genvar s = 0; s < NS; s++) begin : g_stage
    localparam logic [spe_pkg::PROD_W-1:0] SUB =
      spe_pkg::PROD_W'(spe_pkg::TWO_PI_Q32 << (NS - 1 - s));
    logic                       vi;
    logic [spe_pkg::PROD_W-1:0] ri;
    spe_pkg::tag_t              ti;
    logic [spe_pkg::PROD_W-1:0] rem_nxt;

    if (s == 0) begin : g_first
      assign vi = in_valid;
      assign ri = in_prod;
      assign ti = in_tag;
    end else begin : g_next
      assign vi = v_r[s-1];
      assign ri = rem_r[s-1];
      assign ti = tag_r[s-1];
    end

    assign rem_nxt = (ri >= SUB) ? ri - SUB : ri;

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        v_r[s] <= 1'b0;
      end else if (en) begin
        v_r[s] <= vi;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        rem_r[s] <= rem_nxt;
        tag_r[s] <= ti;
      end
    end
  end

  assign out_valid = v_r[NS-1];
  assign out_ang   = rem_r[NS-1][spe_pkg::ANG_W-1:0];
  assign out_tag   = tag_r[NS-1];

endmodule

// File: design/spe_cordic.sv
module spe_cordic #(
  parameter int STEPS = spe_pkg::CORDIC_STEPS_DEF
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           en,
  input  logic                           in_valid,
  input  logic signed [spe_pkg::CD_W-1:0] in_angle,
  input  spe_pkg::tag_t                  in_tag,
  output logic                           out_valid,
  output logic signed [spe_pkg::CD_W-1:0] out_cos,
  output logic signed [spe_pkg::CD_W-1:0] out_sin,
  output spe_pkg::tag_t                  out_tag
);

  logic                           v_r [STEPS];
  logic signed [spe_pkg::CD_W-1:0] x_r [STEPS];
  logic signed [spe_pkg::CD_W-1:0] y_r [STEPS];
  logic signed [spe_pkg::CD_W-1:0] z_r [STEPS];
  spe_pkg::tag_t                  tag_r [STEPS];

  // rotation mode, one micro-rotation per stage
  for (genvar k = 0; k < STEPS; k++) begin : g_stage
    logic                           vi;
    logic signed [spe_pkg::CD_W-1:0] xi, yi, zi;
    spe_pkg::tag_t                  ti;
    logic signed [spe_pkg::CD_W-1:0] xs, ys;
    logic                           up;

    if (k == 0) begin : g_first
      assign vi = in_valid;
      assign xi = spe_pkg::GAIN_Q30;
      assign yi = '0;
      assign zi = in_angle;
      assign ti = in_tag;
    end else begin : g_next
      assign vi = v_r[k-1];
      assign xi = x_r[k-1];
      assign yi = y_r[k-1];
      assign zi = z_r[k-1];
      assign ti = tag_r[k-1];
    end

    assign xs = xi >>> k;
    assign ys = yi >>> k;
    assign up = (zi >= 0);

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        v_r[k] <= 1'b0;
      end else if (en) begin
        v_r[k] <= vi;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        x_r[k]   <= up ? xi - ys : xi + ys;
        y_r[k]   <= up ? yi + xs : yi - xs;
        z_r[k]   <= up ? zi - spe_pkg::ATAN_Q30[k] : zi + spe_pkg::ATAN_Q30[k];
        tag_r[k] <= ti;
      end
    end
  end

  assign out_valid = v_r[STEPS-1];
  assign out_cos   = x_r[STEPS-1];
  assign out_sin   = y_r[STEPS-1];
  assign out_tag   = tag_r[STEPS-1];

endmodule

// File: design/sinusoidal_position_encoder_core.sv
// Adds the sinusoidal position code to a stream of embedding elements. Each input
// transaction carries a sequence position, a column and a signed Q4.12 element; each
// output transaction returns element + sin(pos*w) (even column) or cos(pos*w) (odd
// column), saturated to Q4.12, with w = 10000^(-2i/MODEL_WIDTH) read from a frequency
// rom of MODEL_WIDTH/2 entries built at elaboration. Columns beyond the last
// complete sin/cos pair pass the element through, and positions wrap modulo
// MAX_POSITION. The block takes one transaction every clock while in_tready is high
// and keeps results in order through the nine-stage modulo-two-pi reduction and the
// one-stage-per-step cordic. The pipeline advances as a whole; a two-entry output
// buffer lets one more result land while the output is stalled, and in_tready drops
// only once that buffer is full.
module sinusoidal_position_encoder_core #(
  parameter int MODEL_WIDTH  = spe_pkg::MODEL_WIDTH_DEF,
  parameter int MAX_POSITION = spe_pkg::MAX_POSITION_DEF,
  parameter int CORDIC_STEPS = spe_pkg::CORDIC_STEPS_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [39:0] in_tdata,    // position[10:0], column[22:11], element_value[38:23]
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [15:0] out_tdata    // encoded_value[15:0]
);

  localparam int POS_W  = spe_pkg::POS_W;
  localparam int COL_W  = spe_pkg::COL_W;
  localparam int VAL_W  = spe_pkg::VAL_W;
  localparam int CODE_W = spe_pkg::CODE_W;
  localparam int INV_W  = spe_pkg::INV_W;
  localparam int PROD_W = spe_pkg::PROD_W;
  localparam int ANG_W  = spe_pkg::ANG_W;
  localparam int CD_W   = spe_pkg::CD_W;
  localparam int TH_W   = spe_pkg::TH_W;

  // coded columns and frequency rom shape
  localparam int HALF_W    = MODEL_WIDTH / 2;
  localparam int COL_LIM   = 2 * HALF_W;
  localparam int IDX_W     = (HALF_W > 1) ? $clog2(HALF_W) : 1;
  localparam int ROM_DEPTH = 1 << IDX_W;

  // position wrap: reciprocal estimate is low by at most one, fixed by one subtract
  localparam int RECIP_SH = 24;
  localparam int RECIP_W  = RECIP_SH + 1;
  localparam int POSM_W   = 17;  // holds MAX_POSITION up to 65536
  localparam logic [RECIP_W-1:0] POS_RECIP = RECIP_W'((1 << RECIP_SH) / MAX_POSITION);
  localparam logic [POSM_W-1:0]  MAXP      = POSM_W'(MAX_POSITION);

  // -------------------------------------------------------------------------
  // input unpack and pipeline enable
  // -------------------------------------------------------------------------
  logic [POS_W-1:0]        in_pos;
  logic [COL_W-1:0]        in_col;
  logic signed [VAL_W-1:0] in_elem;
  logic                    en;
  logic                    in_acc;
  logic                    skid_valid_r;

  assign in_pos  = in_tdata[10:0];
  assign in_col  = in_tdata[22:11];
  assign in_elem = in_tdata[38:23];

  // whole pipeline moves unless the output buffer is full
  assign en        = !skid_valid_r;
  assign in_tready = en;
  assign in_acc    = in_tvalid && en;

  // -------------------------------------------------------------------------
  // frequency rom, filled at elaboration
  // -------------------------------------------------------------------------
  logic [INV_W-1:0] inv_rom [ROM_DEPTH];

  for (genvar g = 0; g < ROM_DEPTH; g++) begin : g_rom
    localparam logic [63:0] XQ =
      (64'(2) * 64'(g) * spe_pkg::LN10000_Q32) / 64'(MODEL_WIDTH);
    assign inv_rom[g] = (g < HALF_W) ? spe_pkg::inv_freq(XQ) : '0;
  end

  // -------------------------------------------------------------------------
  // stage 1: rom read, position quotient estimate
  // -------------------------------------------------------------------------
  spe_pkg::tag_t    in_tag;
  logic [POS_W-1:0] s1_q_nxt;
  logic             s1_v_r;
  logic [POS_W-1:0] s1_pos_r;
  logic [POS_W-1:0] s1_q_r;
  logic [INV_W-1:0] s1_inv_r;
  spe_pkg::tag_t    s1_tag_r;

  assign in_tag.odd  = in_col[0];
  assign in_tag.pass = ({1'b0, in_col} >= (COL_W + 1)'(COL_LIM));
  assign in_tag.neg  = 1'b0;
  assign in_tag.elem = in_elem;

  assign s1_q_nxt = POS_W'(((POS_W + RECIP_W)'(in_pos) * (POS_W + RECIP_W)'(POS_RECIP))
                           >> RECIP_SH);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
    end else if (en) begin
      s1_v_r <= in_acc;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s1_pos_r <= in_pos;
      s1_q_r   <= s1_q_nxt;
      s1_inv_r <= inv_rom[in_col[IDX_W:1]];
      s1_tag_r <= in_tag;
    end
  end

  // -------------------------------------------------------------------------
  // stage 2: partial remainder of the position wrap
  // -------------------------------------------------------------------------
  logic [POS_W-1:0] s2_r_nxt;
  logic             s2_v_r;
  logic [POS_W-1:0] s2_r_r;
  logic [INV_W-1:0] s2_inv_r;
  spe_pkg::tag_t    s2_tag_r;

  // quotient never exceeds the true one, so q*M fits the position width
  assign s2_r_nxt = s1_pos_r - POS_W'((POS_W + POSM_W)'(s1_q_r) * (POS_W + POSM_W)'(MAXP));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_v_r <= 1'b0;
    end else if (en) begin
      s2_v_r <= s1_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s2_r_r   <= s2_r_nxt;
      s2_inv_r <= s1_inv_r;
      s2_tag_r <= s1_tag_r;
    end
  end

  // -------------------------------------------------------------------------
  // stage 3: final position correction
  // -------------------------------------------------------------------------
  logic [POS_W-1:0] s3_pos_nxt;
  logic             s3_v_r;
  logic [POS_W-1:0] s3_pos_r;
  logic [INV_W-1:0] s3_inv_r;
  spe_pkg::tag_t    s3_tag_r;

  assign s3_pos_nxt = (POSM_W'(s2_r_r) >= MAXP) ? POS_W'(POSM_W'(s2_r_r) - MAXP) : s2_r_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s3_v_r <= 1'b0;
    end else if (en) begin
      s3_v_r <= s2_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s3_pos_r <= s3_pos_nxt;
      s3_inv_r <= s2_inv_r;
      s3_tag_r <= s2_tag_r;
    end
  end

  // -------------------------------------------------------------------------
  // stage 4: angle = position * inverse frequency (q32)
  // -------------------------------------------------------------------------
  logic              s4_v_r;
  logic [PROD_W-1:0] s4_prod_r;
  spe_pkg::tag_t     s4_tag_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s4_v_r <= 1'b0;
    end else if (en) begin
      s4_v_r <= s3_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s4_prod_r <= PROD_W'(s3_pos_r) * PROD_W'(s3_inv_r);
      s4_tag_r  <= s3_tag_r;
    end
  end

  // -------------------------------------------------------------------------
  // angle modulo two pi
  // -------------------------------------------------------------------------
  logic             am_v;
  logic [ANG_W-1:0] am_ang;
  spe_pkg::tag_t    am_tag;

  spe_angle_mod u_angle_mod (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (en),
    .in_valid  (s4_v_r),
    .in_prod   (s4_prod_r),
    .in_tag    (s4_tag_r),
    .out_valid (am_v),
    .out_ang   (am_ang),
    .out_tag   (am_tag)
  );

  // -------------------------------------------------------------------------
  // fold 1: q32 -> q30 and wrap into [-pi, pi)
  // -------------------------------------------------------------------------
  logic signed [TH_W-1:0] f1_th0;
  logic signed [TH_W-1:0] f1_th_nxt;
  logic                   f1_v_r;
  logic signed [TH_W-1:0] f1_th_r;
  spe_pkg::tag_t          f1_tag_r;

  assign f1_th0    = $signed(TH_W'(am_ang[ANG_W-1:2]));
  assign f1_th_nxt = (f1_th0 >= spe_pkg::PI_Q30) ? f1_th0 - spe_pkg::TWO_PI_Q30 : f1_th0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      f1_v_r <= 1'b0;
    end else if (en) begin
      f1_v_r <= am_v;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      f1_th_r  <= f1_th_nxt;
      f1_tag_r <= am_tag;
    end
  end

  // -------------------------------------------------------------------------
  // fold 2: into [-pi/2, pi/2], remembering the sign flip
  // -------------------------------------------------------------------------
  logic signed [TH_W-1:0] f2_th_nxt;
  spe_pkg::tag_t          f2_tag_nxt;
  logic                   f2_v_r;
  logic signed [CD_W-1:0] f2_th_r;
  spe_pkg::tag_t          f2_tag_r;

  always_comb begin
    f2_th_nxt  = f1_th_r;
    f2_tag_nxt = f1_tag_r;
    priority if (f1_th_r > spe_pkg::HALF_PI_Q30) begin
      f2_th_nxt      = f1_th_r - spe_pkg::PI_Q30;
      f2_tag_nxt.neg = 1'b1;
    end else if (f1_th_r < -spe_pkg::HALF_PI_Q30) begin
      f2_th_nxt      = f1_th_r + spe_pkg::PI_Q30;
      f2_tag_nxt.neg = 1'b1;
    end else begin
      f2_th_nxt = f1_th_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      f2_v_r <= 1'b0;
    end else if (en) begin
      f2_v_r <= f1_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      f2_th_r  <= CD_W'(f2_th_nxt);
      f2_tag_r <= f2_tag_nxt;
    end
  end

  // -------------------------------------------------------------------------
  // cordic rotation
  // -------------------------------------------------------------------------
  logic                   cd_v;
  logic signed [CD_W-1:0] cd_cos;
  logic signed [CD_W-1:0] cd_sin;
  spe_pkg::tag_t          cd_tag;

  spe_cordic #(
    .STEPS (CORDIC_STEPS)
  ) u_cordic (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (en),
    .in_valid  (f2_v_r),
    .in_angle  (f2_th_r),
    .in_tag    (f2_tag_r),
    .out_valid (cd_v),
    .out_cos   (cd_cos),
    .out_sin   (cd_sin),
    .out_tag   (cd_tag)
  );

  // -------------------------------------------------------------------------
  // round to q12, apply fold sign, drop the code for pass-through columns
  // -------------------------------------------------------------------------
  logic signed [CD_W-1:0]   rd_sel;
  logic signed [CD_W:0]     rd_sum;
  logic signed [CODE_W-1:0] rd_code;
  logic signed [CODE_W-1:0] r1_code_nxt;
  logic                     r1_v_r;
  logic signed [CODE_W-1:0] r1_code_r;
  logic signed [VAL_W-1:0]  r1_elem_r;

  assign rd_sel  = cd_tag.odd ? cd_cos : cd_sin;
  assign rd_sum  = (CD_W + 1)'(rd_sel) + (CD_W + 1)'(1 << 17);
  assign rd_code = CODE_W'(rd_sum >>> 18);

  always_comb begin
    priority if (cd_tag.pass) begin
      r1_code_nxt = '0;
    end else if (cd_tag.neg) begin
      r1_code_nxt = -rd_code;
    end else begin
      r1_code_nxt = rd_code;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      r1_v_r <= 1'b0;
    end else if (en) begin
      r1_v_r <= cd_v;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      r1_code_r <= r1_code_nxt;
      r1_elem_r <= cd_tag.elem;
    end
  end

  // -------------------------------------------------------------------------
  // saturating add into the output buffer
  // -------------------------------------------------------------------------
  logic signed [VAL_W:0]   sum_w;
  logic signed [VAL_W-1:0] sat_w;
  logic                    land;      // a result leaves the pipeline this cycle
  logic                    out_valid_r;
  logic [VAL_W-1:0]        out_data_r;
  logic [VAL_W-1:0]        skid_data_r;

  assign sum_w = (VAL_W + 1)'(r1_elem_r) + (VAL_W + 1)'(r1_code_r);

  always_comb begin
    priority if (sum_w > (VAL_W + 1)'(signed'(16'sh7fff))) begin
      sat_w = 16'sh7fff;
    end else if (sum_w < -(VAL_W + 1)'(signed'(17'sh08000))) begin
      sat_w = 16'sh8000;
    end else begin
      sat_w = VAL_W'(sum_w);
    end
  end

  assign land = en && r1_v_r;

  // output register with one skid entry behind it
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else if (!out_valid_r || out_tready) begin
      if (skid_valid_r) begin
        out_valid_r  <= 1'b1;
        skid_valid_r <= 1'b0;
      end else begin
        out_valid_r <= land;
      end
    end else if (land) begin
      skid_valid_r <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!out_valid_r || out_tready) begin
      out_data_r <= skid_valid_r ? skid_data_r : sat_w;
    end
    if (out_valid_r && !out_tready && land) begin
      skid_data_r <= sat_w;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

  // -------------------------------------------------------------------------
  // assertions
  // -------------------------------------------------------------------------
  // the skid entry only holds data behind a waiting output
  a_skid_behind_out : assert property (@(posedge clk) disable iff (!rst_n)
    skid_valid_r |-> out_valid_r)
    else $error("skid entry full while output register empty");

  // the skid entry fills only from a stalled output
  a_skid_fill_cause : assert property (@(posedge clk) disable iff (!rst_n)
    $rose(skid_valid_r) |-> $past(out_valid_r && !out_tready))
    else $error("skid entry filled without an output stall");

  // folded angle stays within the cordic convergence range
  a_fold_range : assert property (@(posedge clk) disable iff (!rst_n)
    f2_v_r |-> (TH_W'(f2_th_r) <= spe_pkg::HALF_PI_Q30 &&
                TH_W'(f2_th_r) >= -spe_pkg::HALF_PI_Q30))
    else $error("folded angle outside [-pi/2, pi/2]");

  // rounded position code stays within plus or minus one
  a_code_range : assert property (@(posedge clk) disable iff (!rst_n)
    r1_v_r |-> (r1_code_r <= 14'sd4096 && r1_code_r >= -14'sd4096))
    else $error("position code outside [-1.0, 1.0]");

endmodule
